@@ src/dsq_pkg.sv @@
// ---------------------------------------------------------------------------
// Drum step sequencer package
// Shared types, operation codes, constants and controller/datapath links.
// ---------------------------------------------------------------------------
package dsq_pkg;

    localparam int NumRegs  = 6;
    localparam int StoreAw  = 6;   // {voice, row} word address
    localparam int WordW    = 56;  // eight columns of 7-bit velocity

    localparam logic [7:0]  NOTE_ON_BYTE  = 8'h90;
    localparam logic [7:0]  NOTE_OFF_BYTE = 8'h80;
    localparam logic [6:0]  HIT_VELOCITY  = 7'd96;

    localparam logic [23:0] RST_STEP_PERIOD = 24'd6000;
    localparam logic [3:0]  RST_COLUMNS     = 4'd8;
    localparam logic [55:0] RST_NOTES       = 56'd28945136017331236;
    localparam logic [7:0]  RST_ENABLE      = 8'hFF;
    localparam logic [4:0]  RST_CHANNEL     = 5'd10;
    localparam logic [15:0] RST_BLOCK_LEN   = 16'd4096;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_PERIOD  = 3'd0;
    localparam logic [2:0] REG_COLUMNS = 3'd1;
    localparam logic [2:0] REG_NOTES   = 3'd2;
    localparam logic [2:0] REG_ENABLE  = 3'd3;
    localparam logic [2:0] REG_CHANNEL = 3'd4;
    localparam logic [2:0] REG_BLOCK   = 3'd5;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_TOGGLE = 3'd1,
        OP_FILL   = 3'd2,
        OP_CLRV   = 3'd3,
        OP_CLRALL = 3'd4,
        OP_START  = 3'd5,
        OP_STOP   = 3'd6,
        OP_NONE   = 3'd7
    } op_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] voice;
        logic [5:0] grid_step;
        logic [6:0] velocity;
        logic [6:0] pulses;
        logic [5:0] rotation;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0]  status_byte;
        logic [6:0]  note_number;
        logic [6:0]  note_velocity;
        logic [23:0] delay_frames;
        logic [5:0]  playhead;
        logic        last;
    } evt_item_t;

    typedef struct packed {
        logic [23:0] step_period;
        logic [3:0]  used_columns;
        logic [55:0] voice_notes;
        logic [7:0]  voice_enable;
        logic [4:0]  midi_channel;
        logic [15:0] block_length;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic exec;
        logic tog_rd;
        logic tog_wr;
        logic fill_mod;
        logic fill_acc;
        logic fill_run;
        logic scan;
        logic emit;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] op;
        logic       fire;
        logic       mod_done;
        logic       acc_done;
        logic       fill_done;
        logic       scan_done;
        logic       emit_done;
    } dp_sts_t;

endpackage

@@ src/dsq_ctrl.sv @@
// ---------------------------------------------------------------------------
// Drum step sequencer controller
// One-hot state machine that sequences each operation through the datapath.
// ---------------------------------------------------------------------------
module dsq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  dsq_pkg::dp_sts_t  sts,
    output dsq_pkg::ctl_cmd_t cmd
);
    import dsq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_EXEC     = 9'b000000010,
        S_TOG_RD   = 9'b000000100,
        S_TOG_WR   = 9'b000001000,
        S_FILL_MOD = 9'b000010000,
        S_FILL_ACC = 9'b000100000,
        S_FILL_RUN = 9'b001000000,
        S_SCAN     = 9'b010000000,
        S_EMIT     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                case (sts.op)
                    OP_TICK:   state_next = sts.fire ? S_SCAN : S_IDLE;
                    OP_TOGGLE: state_next = S_TOG_RD;
                    OP_FILL:   state_next = S_FILL_MOD;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_TOG_RD:
            begin
                cmd.tog_rd = 1'b1;
                state_next = S_TOG_WR;
            end
            S_TOG_WR:
            begin
                cmd.tog_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_FILL_MOD:
            begin
                cmd.fill_mod = 1'b1;
                if (sts.mod_done)
                begin
                    state_next = S_FILL_ACC;
                end
            end
            S_FILL_ACC:
            begin
                cmd.fill_acc = 1'b1;
                if (sts.acc_done)
                begin
                    state_next = S_FILL_RUN;
                end
            end
            S_FILL_RUN:
            begin
                cmd.fill_run = 1'b1;
                if (sts.fill_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (sts.emit_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/dsq_dp.sv @@
// ---------------------------------------------------------------------------
// Drum step sequencer datapath
// Velocity store, sample counter, playhead, Euclidean fill walker and the
// event output register.
// ---------------------------------------------------------------------------
module dsq_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  dsq_pkg::cfg_t      cfg,
    input  dsq_pkg::cmd_item_t cmd_data,
    input  dsq_pkg::ctl_cmd_t  cmd,
    output dsq_pkg::dp_sts_t   sts,
    output logic               evt_valid,
    input  logic               evt_ready,
    output dsq_pkg::evt_item_t evt_data
);
    import dsq_pkg::*;

    // Latched input item.
    cmd_item_t item_reg;

    // Velocity store: one word per voice and row, valid bit per word.
    logic [WordW-1:0] mem [2**StoreAw];
    logic [WordW-1:0] rd_data_reg;
    logic             rd_valid_reg;
    logic [2**StoreAw-1:0] valid_reg;
    logic [StoreAw-1:0] rd_addr, wr_addr;
    logic [WordW-1:0]   wr_data;
    logic               wr_en;
    logic [WordW-1:0]   rd_word;

    // Playback state.
    logic [5:0]  ph_reg;
    logic [23:0] cnt_reg;
    logic        run_reg;
    logic [23:0] gate_reg;

    // Fill walker.
    logic [6:0]       rmod_reg, base_reg, acc_reg;
    logic [2:0]       row_reg, col_reg;
    logic [WordW-1:0] word_reg;

    // Scan and emit.
    logic [3:0]       issue_reg;
    logic             pend_reg;
    logic [2:0]       pend_idx_reg;
    logic [7:0]       mask_reg;
    logic [WordW-1:0] vels_reg;
    logic             off_reg;
    evt_item_t        evt_reg;
    logic             evt_valid_reg;

    // Lowest pending voice and emit strobe.
    logic [2:0] sel;
    logic       emit_load;
    logic [7:0] mask_rest;

    // Derived configuration values.
    logic [3:0]  ac;
    logic [6:0]  total;
    logic [23:0] period;
    logic [24:0] cnt_inc;
    logic        fire;
    logic [23:0] gate_half, gate_val;
    logic [3:0]  chan;
    logic [2:0]  ph_row, ph_col, nx_row, nx_col;

    always_comb
    begin
        if (cfg.used_columns == 4'd0)
        begin
            ac = 4'd1;
        end
        else if (cfg.used_columns > 4'd8)
        begin
            ac = 4'd8;
        end
        else
        begin
            ac = cfg.used_columns;
        end
        total   = {ac, 3'b000};
        period  = (cfg.step_period == 24'd0) ? 24'd1 : cfg.step_period;
        cnt_inc = {1'b0, cnt_reg} + 25'd1;
        fire    = run_reg && (cnt_inc >= {1'b0, period});
        gate_half = (period > 24'd1) ? {1'b0, period[23:1]} : 24'd1;
        if (gate_half >= {8'd0, cfg.block_length})
        begin
            gate_val = (cfg.block_length > 16'd1) ?
                       {8'd0, cfg.block_length - 16'd1} : 24'd1;
        end
        else
        begin
            gate_val = gate_half;
        end
        chan = 4'(cfg.midi_channel - 5'd1);
    end

    // Next playhead position over the active columns.
    always_comb
    begin
        ph_row = ph_reg[5:3];
        ph_col = ({1'b0, ph_reg[2:0]} >= ac) ? 3'd0 : ph_reg[2:0];
        if ({1'b0, ph_col} + 4'd1 >= ac)
        begin
            nx_col = 3'd0;
            nx_row = ph_row + 3'd1;
        end
        else
        begin
            nx_col = ph_col + 3'd1;
            nx_row = ph_row;
        end
    end

    // Euclidean walker arithmetic.
    logic [6:0] target, base_inc, acc_inc;
    logic [7:0] acc_sum;
    logic       hit, col_active;
    logic [6:0] cell_val;
    always_comb
    begin
        target   = (rmod_reg == 7'd0) ? 7'd0 : total - rmod_reg;
        base_inc = (base_reg + 7'd1 == total) ? 7'd0 : base_reg + 7'd1;
        acc_sum  = {1'b0, acc_reg} + {1'b0, item_reg.pulses};
        acc_inc  = (acc_sum >= {1'b0, total}) ? 7'(acc_sum - {1'b0, total}) :
                   acc_sum[6:0];
        hit      = (item_reg.pulses != 7'd0) &&
                   ((item_reg.pulses >= total) || (acc_reg < item_reg.pulses));
        col_active = ({1'b0, col_reg} < ac);
        cell_val = (col_active && hit) ? HIT_VELOCITY : 7'd0;
    end

    // Store port selection.
    logic [6:0] old_vel;
    always_comb
    begin
        rd_word = rd_valid_reg ? rd_data_reg : '0;
        old_vel = rd_word[item_reg.grid_step[2:0]*7 +: 7];
        rd_addr = cmd.scan ? {issue_reg[2:0], ph_reg[5:3]} :
                             {item_reg.voice, item_reg.grid_step[5:3]};
        wr_en   = 1'b0;
        wr_addr = {item_reg.voice, row_reg};
        wr_data = word_reg;
        wr_data[col_reg*7 +: 7] = cell_val;
        if (cmd.tog_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = {item_reg.voice, item_reg.grid_step[5:3]};
            wr_data = rd_word;
            wr_data[item_reg.grid_step[2:0]*7 +: 7] =
                (old_vel == 7'd0) ? item_reg.velocity : 7'd0;
        end
        else if (cmd.fill_run && col_reg == 3'd7)
        begin
            wr_en = 1'b1;
        end
    end

    // Store array with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Word valid bits; a clear drops them at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            else if (cmd.exec && item_reg.operation == OP_CLRALL)
            begin
                valid_reg <= '0;
            end
            else if (cmd.exec && item_reg.operation == OP_CLRV)
            begin
                valid_reg[item_reg.voice*8 +: 8] <= 8'd0;
            end
        end
    end

    // Input latch.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_reg <= cmd_data;
        end
    end

    // Playback counter, playhead and run flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= '0;
            cnt_reg <= '0;
            run_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            case (item_reg.operation)
                OP_TICK:
                begin
                    if (fire)
                    begin
                        cnt_reg <= '0;
                        ph_reg  <= {nx_row, nx_col};
                    end
                    else if (run_reg)
                    begin
                        cnt_reg <= cnt_inc[23:0];
                    end
                end
                OP_START:
                begin
                    run_reg <= 1'b1;
                    ph_reg  <= '0;
                    cnt_reg <= '0;
                end
                OP_STOP:
                begin
                    run_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Euclidean fill: reduce rotation, preload the accumulator, then walk.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rmod_reg <= {1'b0, item_reg.rotation};
            base_reg <= '0;
            acc_reg  <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            word_reg <= '0;
        end
        else if (cmd.fill_mod)
        begin
            if (rmod_reg >= total)
            begin
                rmod_reg <= rmod_reg - total;
            end
        end
        else if (cmd.fill_acc)
        begin
            if (base_reg != target)
            begin
                base_reg <= base_inc;
                acc_reg  <= acc_inc;
            end
        end
        else if (cmd.fill_run)
        begin
            word_reg[col_reg*7 +: 7] <= cell_val;
            if (col_active)
            begin
                base_reg <= base_inc;
                acc_reg  <= acc_inc;
            end
            col_reg <= col_reg + 3'd1;
            if (col_reg == 3'd7)
            begin
                row_reg <= row_reg + 3'd1;
            end
        end
    end

    // Scan of all voices at the new playhead.
    logic [6:0] scan_vel;
    assign scan_vel = rd_word[ph_reg[2:0]*7 +: 7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            mask_reg     <= '0;
            off_reg      <= 1'b0;
            gate_reg     <= '0;
            vels_reg     <= '0;
        end
        else if (cmd.exec)
        begin
            issue_reg <= '0;
            pend_reg  <= 1'b0;
            mask_reg  <= '0;
            off_reg   <= 1'b0;
            gate_reg  <= gate_val;
        end
        else if (cmd.scan)
        begin
            if (!issue_reg[3])
            begin
                issue_reg <= issue_reg + 4'd1;
            end
            pend_reg     <= !issue_reg[3];
            pend_idx_reg <= issue_reg[2:0];
            if (pend_reg)
            begin
                vels_reg[pend_idx_reg*7 +: 7] <= scan_vel;
                mask_reg[pend_idx_reg] <= cfg.voice_enable[pend_idx_reg] &&
                                          (scan_vel != 7'd0);
            end
        end
        else if (emit_load)
        begin
            off_reg <= !off_reg;
            if (off_reg)
            begin
                mask_reg[sel] <= 1'b0;
            end
        end
    end

    // Lowest pending voice.
    always_comb
    begin
        sel = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = 3'(i);
            end
        end
        mask_rest = mask_reg & ~(8'd1 << sel);
        emit_load = cmd.emit && (mask_reg != 8'd0) && (!evt_valid_reg || evt_ready);
    end

    // Event output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            evt_valid_reg <= 1'b1;
        end
        else if (evt_ready)
        begin
            evt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            evt_reg.note_number <= cfg.voice_notes[sel*7 +: 7];
            evt_reg.playhead    <= ph_reg;
            if (off_reg)
            begin
                evt_reg.status_byte   <= NOTE_OFF_BYTE | {4'd0, chan};
                evt_reg.note_velocity <= 7'd0;
                evt_reg.delay_frames  <= gate_reg;
                evt_reg.last          <= (mask_rest == 8'd0);
            end
            else
            begin
                evt_reg.status_byte   <= NOTE_ON_BYTE | {4'd0, chan};
                evt_reg.note_velocity <= vels_reg[sel*7 +: 7];
                evt_reg.delay_frames  <= 24'd0;
                evt_reg.last          <= 1'b0;
            end
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt_data  = evt_reg;

    // Status to the controller.
    always_comb
    begin
        sts.op        = item_reg.operation;
        sts.fire      = fire;
        sts.mod_done  = (rmod_reg < total);
        sts.acc_done  = (base_reg == target);
        sts.fill_done = (row_reg == 3'd7) && (col_reg == 3'd7);
        sts.scan_done = pend_reg && (pend_idx_reg == 3'd7);
        sts.emit_done = (mask_reg == 8'd0);
    end

endmodule

@@ src/euclidean_drum_step_sequencer_top.sv @@
// ---------------------------------------------------------------------------
// Euclidean drum step sequencer, top level
// Operations arrive on the cmd channel (valid/ready); MIDI note events leave
// on the evt channel (valid/ready). Registers sit on an APB port with 64-bit
// data, register i at byte address 8*i.
// Each accepted operation takes the controller out of idle: start, stop,
// clears, the no-op and non-firing ticks pass through the execute state only,
// a toggle reads the store word and writes it back, and a Euclidean fill
// reduces the rotation, preloads the accumulator and then walks one grid cell
// per cycle for 64 cells. A tick that reaches the step period scans the
// eight voices through the store read port, then loads one event per cycle
// into the output register while the receiver keeps taking them; a tick
// makes at most 16 events.
// The block accepts the next operation in the cycle after the last event of
// a tick is in the output register. A stalled receiver holds the output
// register and stops emission. Reset clears the velocity store at once (word
// valid bits), stops playback, zeroes playhead and count and loads the
// register defaults.
// ---------------------------------------------------------------------------
module euclidean_drum_step_sequencer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  dsq_pkg::cmd_item_t cmd_data,
    output logic               evt_valid,
    input  logic               evt_ready,
    output dsq_pkg::evt_item_t evt_data
);
    import dsq_pkg::*;

    cfg_t      cfg_reg;
    ctl_cmd_t  cmd;
    dp_sts_t   sts;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];

    // Register writes on the APB access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_period    <= RST_STEP_PERIOD;
            cfg_reg.used_columns   <= RST_COLUMNS;
            cfg_reg.voice_notes    <= RST_NOTES;
            cfg_reg.voice_enable   <= RST_ENABLE;
            cfg_reg.midi_channel   <= RST_CHANNEL;
            cfg_reg.block_length   <= RST_BLOCK_LEN;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_PERIOD:  cfg_reg.step_period    <= pwdata[23:0];
                REG_COLUMNS: cfg_reg.used_columns   <= pwdata[3:0];
                REG_NOTES:   cfg_reg.voice_notes    <= pwdata[55:0];
                REG_ENABLE:  cfg_reg.voice_enable   <= pwdata[7:0];
                REG_CHANNEL: cfg_reg.midi_channel   <= pwdata[4:0];
                REG_BLOCK:   cfg_reg.block_length   <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register read mux.
    always_comb
    begin
        case (reg_idx)
            REG_PERIOD:  prdata = {40'd0, cfg_reg.step_period};
            REG_COLUMNS: prdata = {60'd0, cfg_reg.used_columns};
            REG_NOTES:   prdata = {8'd0, cfg_reg.voice_notes};
            REG_ENABLE:  prdata = {56'd0, cfg_reg.voice_enable};
            REG_CHANNEL: prdata = {59'd0, cfg_reg.midi_channel};
            REG_BLOCK:   prdata = {48'd0, cfg_reg.block_length};
            default:     prdata = 64'd0;
        endcase
    end

    dsq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dsq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_data  (cmd_data),
        .cmd       (cmd),
        .sts       (sts),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt_data  (evt_data)
    );

endmodule
